>>> rtl/crc16_key_hash_slot_unit_macros.svh
// Assertion macros used by the key hash slot checker.
`ifndef CRC16_KEY_HASH_SLOT_UNIT_MACROS_SVH
`define CRC16_KEY_HASH_SLOT_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CKHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CKHS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/ckhs_pkg.sv
// ----------------------------------------------------------------------------
// ckhs_pkg
// Types, constants and the CRC-16/XMODEM byte step for the key hash slot unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckhs_pkg;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [7:0]  OpenBrace  = 8'h7b;
  localparam logic [7:0]  CloseBrace = 8'h7d;
  localparam int unsigned SlotWidth  = 14;

  // Tag scan phase, one-hot.
  typedef enum logic [2:0] {
    PhaseBefore = 3'b001,
    PhaseInside = 3'b010,
    PhaseClosed = 3'b100
  } phase_e;

  // MSB-first CRC-16 update by one byte, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crc16_key_hash_slot_unit.sv
// ----------------------------------------------------------------------------
// crc16_key_hash_slot_unit
// Streams a key in byte by byte and gives its cluster hash slot (CRC-16/XMODEM
// of its first {tag} if that tag is non-empty, else of the whole key) after the last beat.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, key_byte_i,          | in
//          | byte_present_i, last_byte_i                  |
//  out     | out_valid_o, out_stall_i, slot_o             | out
//
//  One beat per cycle sustained while no slot is blocked at the output; the per-byte
//  CRC XOR tree feeding the CRC state registers sets the cycle.
//  The key-ending beat passes the input register; slot_o and out_valid_o are then
//  registered in the result register, where the slot beat can be taken.
//  Async reset clears valids and the CRC/tag state; nothing else to clear.
//  in_stall_o rises only when a slot waits at the output while a key-ending
//  beat sits in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_key_hash_slot_unit #(
  parameter int unsigned SLOT_COUNT = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [ckhs_pkg::SlotWidth-1:0] slot_o
);

  localparam logic [15:0] SlotMask = 16'(SLOT_COUNT - 1);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       present_q;
  logic       last_q;

  // key state
  logic [15:0]      whole_crc_q, whole_crc_d;
  logic [15:0]      tag_crc_q, tag_crc_d;
  ckhs_pkg::phase_e phase_q, phase_d;
  logic             tag_nonempty_q, tag_nonempty_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [ckhs_pkg::SlotWidth-1:0] slot_q, slot_d;

  logic        advance;
  logic        in_take;
  logic [15:0] whole_upd, tag_upd, chosen;
  ckhs_pkg::phase_e phase_upd;
  logic        nonempty_upd;

  // A non-final beat never needs the output register.
  assign advance    = in_valid_q & (~last_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_take | (in_valid_q & ~advance);

  always_comb begin
    whole_upd    = whole_crc_q;
    tag_upd      = tag_crc_q;
    phase_upd    = phase_q;
    nonempty_upd = tag_nonempty_q;
    if (present_q) begin
      whole_upd = ckhs_pkg::crc16_byte(whole_crc_q, byte_q);
      case (phase_q)
        ckhs_pkg::PhaseBefore: begin
          if (byte_q == ckhs_pkg::OpenBrace) begin
            phase_upd = ckhs_pkg::PhaseInside;
          end
        end
        ckhs_pkg::PhaseInside: begin
          if (byte_q == ckhs_pkg::CloseBrace) begin
            phase_upd = ckhs_pkg::PhaseClosed;
          end else begin
            tag_upd      = ckhs_pkg::crc16_byte(tag_crc_q, byte_q);
            nonempty_upd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign chosen = (phase_upd == ckhs_pkg::PhaseClosed && nonempty_upd) ? tag_upd : whole_upd;
  assign slot_d = ckhs_pkg::SlotWidth'(chosen & SlotMask);

  always_comb begin
    whole_crc_d    = whole_crc_q;
    tag_crc_d      = tag_crc_q;
    phase_d        = phase_q;
    tag_nonempty_d = tag_nonempty_q;
    if (advance) begin
      if (last_q) begin
        whole_crc_d    = '0;
        tag_crc_d      = '0;
        phase_d        = ckhs_pkg::PhaseBefore;
        tag_nonempty_d = 1'b0;
      end else begin
        whole_crc_d    = whole_upd;
        tag_crc_d      = tag_upd;
        phase_d        = phase_upd;
        tag_nonempty_d = nonempty_upd;
      end
    end
  end

  assign out_valid_d = (advance & last_q) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      whole_crc_q    <= '0;
      tag_crc_q      <= '0;
      phase_q        <= ckhs_pkg::PhaseBefore;
      tag_nonempty_q <= 1'b0;
    end else begin
      in_valid_q     <= in_valid_d;
      out_valid_q    <= out_valid_d;
      whole_crc_q    <= whole_crc_d;
      tag_crc_q      <= tag_crc_d;
      phase_q        <= phase_d;
      tag_nonempty_q <= tag_nonempty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q    <= key_byte_i;
      present_q <= byte_present_i;
      last_q    <= last_byte_i;
    end
    if (advance & last_q) begin
      slot_q <= slot_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;

endmodule

>>> rtl/ckhs_checker.sv
// ----------------------------------------------------------------------------
// ckhs_checker
// Port-level checks for the key hash slot unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc16_key_hash_slot_unit_macros.svh"

module ckhs_checker #(
  parameter int unsigned SLOT_COUNT = 16384
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] slot_o
);

  localparam logic [13:0] SlotMask = 14'(SLOT_COUNT - 1);

  // held slot beat keeps its value
  `CKHS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o), "slot beat changed while stalled")

  // input backpressure only comes from a blocked result
  `CKHS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a blocked slot")

  // slot never exceeds the slot count
  `CKHS_ASSERT(a_slot_range, out_valid_o |-> ((slot_o & ~SlotMask) == 14'd0), "slot outside slot count")

  `CKHS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind crc16_key_hash_slot_unit ckhs_checker #(.SLOT_COUNT(SLOT_COUNT)) u_ckhs_checker (.*);
